>>> src/trz_pkg.sv
// Package for the trapezoidal-rule integrator: sequencer states, phases,
// shared unit operation codes and request struct. No dependencies.
package trz_pkg;

  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [32:0] ONE_Q31 = 33'h0_8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_CASE,
    ST_UDIV,
    ST_Q,
    ST_RSTART,
    ST_RDIV,
    ST_SQRT,
    ST_ACC,
    ST_SC1,
    ST_SC2,
    ST_SC3,
    ST_OUT
  } trz_state_e;

  typedef enum logic [1:0] {
    PH_LOWER,
    PH_UPPER,
    PH_INNER
  } trz_phase_e;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } trz_op_e;

  typedef struct packed {
    logic    start;
    trz_op_e op;
  } trz_unit_req_t;

endpackage

>>> src/trz_in_if.sv
// Job request channel of the integrator: limits, count and step.
// Depends on nothing.
interface trz_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] lower_limit;
  logic [31:0] upper_limit;
  logic [15:0] trapezoid_count;
  logic [31:0] step_width;

  modport source (output valid, lower_limit, upper_limit, trapezoid_count, step_width,
                  input ready);
  modport sink   (input valid, lower_limit, upper_limit, trapezoid_count, step_width,
                  output ready);
endinterface

>>> src/trz_out_if.sv
// Result channel of the integrator: Q32.32 integral and saturation flag.
// Depends on nothing.
interface trz_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] integral;
  logic        saturated;

  modport source (output valid, integral, saturated, input ready);
  modport sink   (input valid, integral, saturated, output ready);
endinterface

>>> src/trz_divsqrt.sv
// Shared bit-serial unit: restoring division (one quotient bit a cycle)
// and integer square root (one root bit a cycle). Depends on trz_pkg.
module trz_divsqrt #(
  parameter int DVW = 92
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  trz_pkg::trz_unit_req_t req_i,
  input  logic [DVW-1:0]        dividend_i,
  input  logic [63:0]           divisor_i,
  input  logic [63:0]           radicand_i,
  output logic                  done_o,
  output logic [DVW-1:0]        quotient_o,
  output logic [31:0]           root_o
);
  import trz_pkg::*;

  localparam int CNTW = $clog2(DVW + 1);

  logic            busy_q, done_q;
  trz_op_e         op_q;
  logic [CNTW-1:0] cnt_q, last;
  logic [DVW-1:0]  dvd_q, dvd_n;
  logic [63:0]     rem_q, dsr_q, rem_n;
  logic [31:0]     root_q, root_n;

  logic [64:0] rem_div;
  logic        ge;
  logic [35:0] rem_t, trial;
  logic        sge;

  always_comb begin
    rem_div = {rem_q, dvd_q[DVW-1]};
    ge      = rem_div >= {1'b0, dsr_q};
    rem_t   = {rem_q[33:0], dvd_q[63:62]};
    trial   = {2'b00, root_q, 2'b01};
    sge     = rem_t >= trial;
    if (op_q == OP_DIV) begin
      last   = CNTW'(DVW - 1);
      rem_n  = ge ? 64'(rem_div - {1'b0, dsr_q}) : rem_div[63:0];
      dvd_n  = {dvd_q[DVW-2:0], ge};
      root_n = root_q;
    end else begin
      last   = CNTW'(31);
      rem_n  = sge ? 64'(rem_t - trial) : 64'(rem_t);
      dvd_n  = {dvd_q[DVW-3:0], 2'b00};
      root_n = {root_q[30:0], sge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_DIV;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        op_q   <= req_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNTW'(1);
        if (cnt_q == last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q  <= (req_i.op == OP_DIV) ? dividend_i : DVW'(radicand_i);
      dsr_q  <= divisor_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= dvd_n;
      rem_q  <= rem_n;
      root_q <= root_n;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;
  assign root_o     = root_q;

endmodule

>>> src/trapezoid_rule_integrator.sv
// Trapezoidal-rule integrator of sqrt((1+x^2)/(1+x^4)), fixed point.
// Depends on trz_pkg, trz_in_if, trz_out_if and trz_divsqrt.
//
//  channel | dir | contents
//  in_i    | in  | lower_limit, upper_limit, trapezoid_count, step_width
//  out_o   | out | integral (Q32.32), saturated
//
// Samples run SQ, CASE, UDIV (if x^2 > 1), Q, RSTART, RDIV, SQRT and ACC with
// the serial divide/sqrt unit (DVW = max(2*FRAC_BITS+32, 65)); a job takes
// max(n+1, 2) samples, then SC1, SC2, SC3 and OUT. The block takes one request
// at a time and holds ready low until the result is taken, so a stalled result
// side adds its stall to the job. Reset clears the sequencer and the accumulator.
module trapezoid_rule_integrator #(
  parameter int FRAC_BITS   = 24,
  parameter int COUNT_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  trz_in_if.sink    in_i,
  trz_out_if.source out_o
);
  import trz_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int CW   = COUNT_WIDTH;
  localparam int NW   = (CW < 16) ? CW : 16;
  localparam int DVW  = (2 * F + 32 > 65) ? 2 * F + 32 : 65;
  localparam int SH_R = (2 * F >= 31) ? 2 * F - 31 : 0;
  localparam int SH_L = (2 * F >= 31) ? 0 : 31 - 2 * F;

  trz_state_e state_q, state_d;
  trz_phase_e phase_q;

  logic [31:0]        a_q, b_q, h_q;
  logic [CW-1:0]      n_q, k_q;
  logic signed [63:0] point_q;
  logic [63:0]        s_q, sum_q, t1_q, t2_q, integral_q;
  logic [31:0]        u_q, q_q;
  logic               small_q, sat_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic signed [31:0] x_sat;
  logic [31:0]        mag, hmag, s31;
  logic               is_small, neg;
  logic [32:0]        num, den;
  logic [64:0]        acc_sum;
  logic [64:0]        sc_mag;
  logic [63:0]        lim;

  trz_unit_req_t  ureq;
  logic [DVW-1:0] udvd;
  logic [63:0]    udsr;
  logic           udone;
  logic [DVW-1:0] uquo;
  logic [31:0]    uroot;

  trz_divsqrt #(.DVW(DVW)) u_divsqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (ureq),
    .dividend_i (udvd),
    .divisor_i  (udsr),
    .radicand_i ({31'd0, uquo[32:0]} << 31),
    .done_o     (udone),
    .quotient_o (uquo),
    .root_o     (uroot)
  );

  // datapath
  always_comb begin
    if (point_q > 64'sd2147483647)       x_sat = 32'sh7FFF_FFFF;
    else if (point_q < -64'sd2147483648) x_sat = 32'sh8000_0000;
    else                                 x_sat = point_q[31:0];
    mag      = x_sat[31] ? (~x_sat + 32'd1) : x_sat;
    neg      = h_q[31];
    hmag     = neg ? (~h_q + 32'd1) : h_q;
    lim      = neg ? (POS_MAX + 64'd1) : POS_MAX;
    s31      = 32'((s_q >> SH_R) << SH_L);
    is_small = s_q <= (64'd1 << (2 * F));
    num      = small_q ? (ONE_Q31 + 33'(u_q)) : (33'(q_q) + 33'(u_q));
    den      = ONE_Q31 + 33'(q_q);
    acc_sum  = 65'(sum_q) + 65'({uroot, 1'b0});
    sc_mag   = 65'(t1_q << (32 - F)) + 65'(t2_q);
    case (state_q)
      ST_SQ:   begin mul_a = mag;                  mul_b = mag;  end
      ST_Q:    begin mul_a = u_q;                  mul_b = u_q;  end
      ST_SC1:  begin mul_a = {1'b0, sum_q[62:32]}; mul_b = hmag; end
      ST_SC2:  begin mul_a = sum_q[31:0];          mul_b = hmag; end
      default: begin mul_a = u_q;                  mul_b = u_q;  end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_i.valid) state_d = ST_SQ;
      ST_SQ:     state_d = ST_CASE;
      ST_CASE:   state_d = is_small ? ST_Q : ST_UDIV;
      ST_UDIV:   if (udone) state_d = ST_Q;
      ST_Q:      state_d = ST_RSTART;
      ST_RSTART: state_d = ST_RDIV;
      ST_RDIV:   if (udone) state_d = ST_SQRT;
      ST_SQRT:   if (udone) state_d = ST_ACC;
      ST_ACC: begin
        case (phase_q)
          PH_LOWER: state_d = ST_SQ;
          PH_UPPER: state_d = (n_q > CW'(1)) ? ST_SQ : ST_SC1;
          default:  state_d = ((CW + 1)'(k_q) + (CW + 1)'(1) < (CW + 1)'(n_q)) ? ST_SQ
                                                                               : ST_SC1;
        endcase
      end
      ST_SC1:    state_d = ST_SC2;
      ST_SC2:    state_d = ST_SC3;
      ST_SC3:    state_d = ST_OUT;
      ST_OUT:    if (out_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs and unit requests
  always_comb begin
    in_i.ready  = (state_q == ST_IDLE);
    out_o.valid = (state_q == ST_OUT);
    ureq.start  = 1'b0;
    ureq.op     = OP_DIV;
    udvd        = DVW'(1) << (2 * F + 31);
    udsr        = s_q;
    case (state_q)
      ST_CASE:   ureq.start = !is_small;
      ST_RSTART: begin
        ureq.start = 1'b1;
        udvd       = DVW'(num) << 31;
        udsr       = 64'(den);
      end
      ST_RDIV: begin
        ureq.start = udone;
        ureq.op    = OP_SQRT;
      end
      default: ureq.start = 1'b0;
    endcase
  end

  assign out_o.integral  = integral_q;
  assign out_o.saturated = sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_LOWER;
      sum_q   <= '0;
      k_q     <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: if (in_i.valid) begin
          phase_q <= PH_LOWER;
          sum_q   <= '0;
          sat_q   <= 1'b0;
        end
        ST_ACC: begin
          case (phase_q)
            PH_LOWER: begin
              sum_q   <= 64'(uroot);
              phase_q <= PH_UPPER;
            end
            PH_UPPER: begin
              sum_q   <= sum_q + 64'(uroot);
              k_q     <= CW'(1);
              phase_q <= PH_INNER;
            end
            default: begin
              // clamp at the positive limit
              if (acc_sum > 65'(POS_MAX)) begin
                sum_q <= POS_MAX;
                sat_q <= 1'b1;
              end else begin
                sum_q <= acc_sum[63:0];
              end
              k_q <= k_q + CW'(1);
            end
          endcase
        end
        ST_SC1: k_q <= '0;
        ST_SC3: begin
          if (t1_q >= (64'd1 << (31 + F)) || sc_mag > 65'(lim)) sat_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (in_i.valid) begin
        a_q     <= in_i.lower_limit;
        b_q     <= in_i.upper_limit;
        h_q     <= in_i.step_width;
        n_q     <= CW'(in_i.trapezoid_count[NW-1:0]);
        point_q <= 64'(signed'(in_i.lower_limit));
      end
      ST_SQ:   s_q <= mul_p;
      ST_CASE: begin
        small_q <= is_small;
        u_q     <= s31;
      end
      ST_UDIV: if (udone) u_q <= uquo[31:0];
      ST_Q:    q_q <= mul_p[62:31];
      ST_ACC: begin
        case (phase_q)
          PH_LOWER: point_q <= 64'(signed'(b_q));
          PH_UPPER: point_q <= 64'(signed'(a_q)) + 64'(signed'(h_q));
          default:  point_q <= point_q + 64'(signed'(h_q));
        endcase
      end
      ST_SC1: t1_q <= mul_p;
      ST_SC2: t2_q <= mul_p >> F;
      ST_SC3: begin
        if (t1_q >= (64'd1 << (31 + F)) || sc_mag > 65'(lim))
          integral_q <= neg ? (64'd0 - lim) : lim;
        else
          integral_q <= neg ? (64'd0 - sc_mag[63:0]) : sc_mag[63:0];
      end
      default: ;
    endcase
  end

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid) else $error("ready while result pending");

  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    udone |-> (state_q == ST_UDIV || state_q == ST_RDIV || state_q == ST_SQRT))
    else $error("unit finished outside a wait state");

  a_ret_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready) |=> in_i.ready) else $error("no return to idle");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sum_q[63]) else $error("accumulator above positive limit");

endmodule

>>> tb/trapezoid_rule_integrator_test.sv
// Self-checking testbench for trapezoid_rule_integrator: random jobs with bursty
// requests and a stalling result side, checked against a fixed-point predictor.
// Depends on trz_pkg, trz_in_if, trz_out_if and the integrator RTL.
module trapezoid_rule_integrator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 24;
  localparam longint unsigned SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned Q31_ONE = 64'h8000_0000;

  typedef struct {
    logic [31:0] lower;
    logic [31:0] upper;
    logic [15:0] count;
    logic [31:0] step;
  } job_t;

  typedef struct {
    logic [63:0] integral;
    logic        saturated;
  } estimate_t;

  // floor(num * 2^sh / den), restoring division
  function automatic longint unsigned fix_div(longint unsigned num, longint unsigned den,
                                              int sh);
    longint unsigned q, rem;
    q = num / den;
    rem = num % den;
    for (int i = 0; i < sh; i++) begin
      q = q << 1;
      rem = rem << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // sqrt((1+x^2)/(1+x^4)) in Q.31 at a raw point with FRAC fraction bits
  function automatic longint unsigned curve_q31(longint x);
    longint unsigned mag, sq, one2, s31, u, q, num, den, r;
    if (x > 64'sh7FFF_FFFF) x = 64'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) x = -64'sh8000_0000;
    mag = (x < 0) ? longint'(-x) : longint'(x);
    sq = mag * mag;
    one2 = 64'd1 << (2 * FRAC);
    if (sq <= one2) begin
      s31 = (2 * FRAC >= 31) ? (sq >> (2 * FRAC - 31)) : (sq << (31 - 2 * FRAC));
      q = (s31 * s31) >> 31;
      num = Q31_ONE + s31;
      den = Q31_ONE + q;
    end else begin
      u = fix_div(one2, sq, 31);
      q = (u * u) >> 31;
      num = q + u;
      den = Q31_ONE + q;
    end
    r = fix_div(num, den, 31);
    return int_sqrt(r << 31);
  endfunction

  class integral_scoreboard;
    estimate_t pending[$];
    int errors;
    int jobs;
    int results;

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    function void note_job(job_t j);
      longint a, b, h, k;
      longint unsigned acc, f2, hmag, lim, hi, lo, t1, t2, mag;
      logic sat, neg;
      estimate_t e;
      a = longint'(signed'(j.lower));
      b = longint'(signed'(j.upper));
      h = longint'(signed'(j.step));
      sat = 0;
      acc = curve_q31(a) + curve_q31(b);
      for (k = 1; k + 1 <= longint'(j.count); k++) begin
        f2 = curve_q31(a + k * h) << 1;
        if (acc > SUM_MAX - f2) begin
          acc = SUM_MAX;
          sat = 1;
        end else begin
          acc = acc + f2;
        end
      end
      neg = h < 0;
      hmag = neg ? longint'(-h) : longint'(h);
      lim = neg ? SUM_MAX + 1 : SUM_MAX;
      hi = acc >> 32;
      lo = acc & 64'hFFFF_FFFF;
      t1 = hi * hmag;
      if (t1 >= (64'd1 << (63 - (32 - FRAC)))) begin
        mag = lim;
        sat = 1;
      end else begin
        t1 = t1 << (32 - FRAC);
        t2 = (lo * hmag) >> FRAC;
        mag = t1 + t2;
        if (mag > lim) begin
          mag = lim;
          sat = 1;
        end
      end
      e.integral = neg ? 64'd0 - mag : mag;
      e.saturated = sat;
      pending.push_back(e);
      jobs++;
    endfunction

    task check_result(logic [63:0] integral, logic saturated);
      estimate_t e;
      results++;
      if (pending.size() == 0) begin
        report("unexpected result", integral, 64'd0);
      end else begin
        e = pending.pop_front();
        if (integral !== e.integral) report("integral", integral, e.integral);
        if (saturated !== e.saturated) report("saturated", 64'(saturated), 64'(e.saturated));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  trz_in_if in_ch();
  trz_out_if out_ch();
  integral_scoreboard sb;
  int idle_left;
  bit stall_on;
  int stall_len;

  trapezoid_rule_integrator uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // the watchdog leaves room for the two long-count jobs
  initial begin
    #1_000_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // drive one request and hold it until the block takes it
  task send_job(job_t j);
    in_ch.valid <= 1'b1;
    in_ch.lower_limit <= j.lower;
    in_ch.upper_limit <= j.upper;
    in_ch.trapezoid_count <= j.count;
    in_ch.step_width <= j.step;
    forever begin
      @(negedge clk);
      if (in_ch.ready) begin
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
    sb.note_job(j);
    // bursts: mostly back to back, sometimes a gap
    if (idle_left > 0) begin
      idle_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      idle_left = $urandom_range(0, 5);
    end
  endtask

  task send_fields(logic [31:0] lo_v, logic [31:0] up_v, logic [15:0] n, logic [31:0] h);
    job_t j;
    j.lower = lo_v;
    j.upper = up_v;
    j.count = n;
    j.step = h;
    send_job(j);
  endtask

  function automatic logic [31:0] pick_point();
    case ($urandom_range(0, 3))
      0: return $urandom();
      default: return 32'(signed'($urandom_range(0, 32'h0A00_0000)) - 32'sh0500_0000);
    endcase
  endfunction

  // result side: stall stretches alternating with free-flowing ones
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_on <= 1'b0;
      stall_len <= 0;
    end else begin
      if (stall_len == 0) begin
        stall_on <= ~stall_on;
        stall_len <= $urandom_range(5, 60);
      end else begin
        stall_len <= stall_len - 1;
      end
      out_ch.ready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.integral, out_ch.saturated);
  end

  initial begin
    sb = new();
    idle_left = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.lower_limit = '0;
    in_ch.upper_limit = '0;
    in_ch.trapezoid_count = '0;
    in_ch.step_width = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero step, single and zero trapezoid, range ends, x = 1.0
    send_fields(32'h0, 32'h0, 16'd1, 32'h0);
    send_fields(32'h0, 32'h0100_0000, 16'd0, 32'h0100_0000);
    send_fields(32'h0100_0000, 32'hFF00_0000, 16'd1, 32'h8000_0000);
    send_fields(32'h8000_0000, 32'h7FFF_FFFF, 16'd2, 32'h7FFF_FFFF);
    send_fields(32'h7FFF_FFFF, 32'h8000_0000, 16'd3, 32'h7FFF_FFFF);
    send_fields(32'h8000_0000, 32'h8000_0000, 16'd4, 32'h8000_0000);
    send_fields(32'h0, 32'h0400_0000, 16'd4, 32'h0100_0000);
    send_fields(32'hFF00_0000, 32'h0100_0000, 16'd8, 32'h0040_0000);
    send_fields(32'h0200_0000, 32'hFE00_0000, 16'd5, 32'hFF00_0000);
    send_fields(32'h7000_0000, 32'h7FFF_FFFF, 16'd6, 32'h4000_0000);
    send_fields(32'hFFFF_FFFF, 32'h0000_0001, 16'd2, 32'h0000_0001);
    send_fields(32'h0, 32'h0001_0000, 16'hFFFF, 32'h0000_0001);
    send_fields(32'h0, 32'h0080_0000, 16'h4000, 32'h0000_0200);

    // random: mostly few trapezoids, some medium counts
    repeat (100) begin
      send_fields(pick_point(), pick_point(),
                  ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 80))
                                              : 16'($urandom_range(1, 8)),
                  ($urandom_range(0, 2) == 0) ? $urandom()
                                              : 32'($urandom_range(0, 32'h0200_0000)) -
                                                32'h0100_0000);
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("run covered %0d jobs and %0d results, including range-end and x=1.0 points,",
             sb.jobs, sb.results);
    $display("counts from 0 to 65535 and negative, zero and extreme steps");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> files.f
src/trz_pkg.sv
src/trz_in_if.sv
src/trz_out_if.sv
src/trz_divsqrt.sv
src/trapezoid_rule_integrator.sv
tb/trapezoid_rule_integrator_test.sv
